[rtl/lsr_pkg.sv]
// lsr_pkg: widths, sequencer states and divider request/response types
// for the timestamped linear resampler. No dependencies.

package lsr_pkg;

    localparam int SAMPLE_W  = 32;
    localparam int TIME_W    = 48;
    localparam int RATE_W    = 24;
    localparam int FRAC_W    = 16;
    localparam int DIV_W     = 80;
    localparam int DIVISOR_W = 48;
    localparam int DIV_STEPS = 80;
    localparam int DIV_CNT_W = 7;

    // sequencer states, one-hot
    typedef enum logic [15:0] {
        ST_IDLE    = 16'h0001,
        ST_END_HI  = 16'h0002,
        ST_END_LO  = 16'h0004,
        ST_CHECK   = 16'h0008,
        ST_TQ_GO   = 16'h0010,
        ST_TQ_WAIT = 16'h0020,
        ST_XCALC   = 16'h0040,
        ST_XSTART  = 16'h0080,
        ST_XWAIT   = 16'h0100,
        ST_IDXCHK  = 16'h0200,
        ST_RD_A    = 16'h0400,
        ST_RD_B    = 16'h0800,
        ST_MUL     = 16'h1000,
        ST_VAL     = 16'h2000,
        ST_STORE   = 16'h4000,
        ST_FLUSH   = 16'h8000
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     dividend;
        logic [DIVISOR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

[rtl/lsr_ram.sv]
// lsr_ram: generic single write, single read RAM with registered read data.
// No dependencies.

module lsr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/lsr_div.sv]
// lsr_div: restoring bit-serial divider, one quotient bit per cycle.
// Depends on lsr_pkg for widths and the request/response types.

module lsr_div (
    input  logic              clk,
    input  logic              rst_n,
    input  lsr_pkg::div_req_t req,
    output lsr_pkg::div_rsp_t rsp
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [lsr_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [lsr_pkg::DIV_W-1:0]         q_reg;
    logic [lsr_pkg::DIVISOR_W-1:0]     rem_reg;
    logic [lsr_pkg::DIVISOR_W:0]       trial;
    logic                              ge;

    // trial subtract of the shifted remainder
    assign trial = {rem_reg, q_reg[lsr_pkg::DIV_W-1]};
    assign ge    = trial >= {1'b0, req.divisor};

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + lsr_pkg::DIV_CNT_W'(1);
                if (cnt_reg == lsr_pkg::DIV_CNT_W'(lsr_pkg::DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            q_reg   <= req.dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[lsr_pkg::DIV_W-2:0], ge};
            rem_reg <= ge ? lsr_pkg::DIVISOR_W'(trial - {1'b0, req.divisor})
                          : trial[lsr_pkg::DIVISOR_W-1:0];
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule

[rtl/timestamped_linear_resampler.sv]
// timestamped_linear_resampler: block gathering, block-end timing and
// interpolated output sequencer. Depends on lsr_pkg, lsr_ram, lsr_div.
//
//  channel  direction  handshake             payload
//  cfg      in         cfg_valid/cfg_ready   cfg_rate
//  in       in         in_valid/in_ready     mode, sample, last_in_block, block_end_time
//  out      out        out_valid/out_ready   value, out_index, last_of_run
//
// Plain samples and clear words stream one per cycle while in_ready is high.
// For each output word a block end runs the shared 80-step serial divider for
// tick time and, unless the position is negative, buffer position; a stop on a
// missing neighbor ends the run, and the last word is flushed at its end.
// Reset clears control state at once; the sample RAMs get no clearing pass.
// in_ready is low while a block end runs; a stalled output holds the run.

module timestamped_linear_resampler #(
    parameter int MAX_BLOCK = 32,
    parameter int MAX_OUT   = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [23:0] cfg_rate,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic signed [31:0] sample,
    input  logic        last_in_block,
    input  logic [47:0] block_end_time,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [31:0] value,
    output logic [47:0] out_index,
    output logic        last_of_run
);

    localparam int CW  = $clog2(MAX_BLOCK + 1);
    localparam int AW  = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int SWD = CW + 1;
    localparam int OW  = $clog2(MAX_OUT + 1);

    lsr_pkg::state_t state_reg, state_next;

    logic [23:0]        rate_reg;
    logic               cur_bank_reg;
    logic [CW-1:0]      cur_count_reg;
    logic [CW-1:0]      prev_count_reg;
    logic [47:0]        pet_reg;
    logic [47:0]        oc_reg;
    logic [OW-1:0]      num_reg;
    logic [OW-1:0]      i_reg;
    logic               pend_v_reg;
    logic               out_valid_reg;

    logic [47:0]        tend_reg;
    logic [47:0]        span_reg;
    logic [55:0]        end_hi_reg;
    logic [56:0]        end_tick_reg;
    logic [63:0]        tq_reg;
    logic [63:0]        x_reg;
    logic [63:0]        idx_reg;
    logic [15:0]        f_reg;
    logic signed [31:0] a_reg;
    logic signed [49:0] prod_reg;
    logic [31:0]        v_reg;
    logic [31:0]        pend_val_reg;
    logic [47:0]        pend_k_reg;
    logic               rbank_reg;
    logic [31:0]        value_reg;
    logic [47:0]        out_index_reg;
    logic               last_reg;

    logic               in_acc;
    logic               slot_free;
    logic               push;
    logic               store_go;
    logic [47:0]        k;
    logic [SWD-1:0]     s_count;
    logic               idx_miss;
    logic               run_ok;
    logic [56:0]        diff;
    logic [OW-1:0]      num_next;
    logic [39:0]        lo_prod;
    logic [63:0]        x_next;
    logic [63:0]        d_tq;
    logic [SWD-1:0]     j;
    logic               in_prev;
    logic [SWD-1:0]     jrel;
    logic [AW-1:0]      raddr;
    logic [31:0]        rd0;
    logic [31:0]        rd1;
    logic [31:0]        rdata;
    logic signed [32:0] diff_ab;
    logic signed [49:0] prod_sh;
    logic               wr;
    lsr_pkg::div_req_t  div_req;
    lsr_pkg::div_rsp_t  div_rsp;

    // handshakes
    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == lsr_pkg::ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign store_go  = (state_reg == lsr_pkg::ST_STORE) && (!pend_v_reg || slot_free);
    assign push      = ((state_reg == lsr_pkg::ST_STORE) && pend_v_reg && slot_free)
                     || ((state_reg == lsr_pkg::ST_FLUSH) && slot_free);

    // block-end arithmetic
    assign k        = oc_reg + 48'(i_reg);
    assign s_count  = SWD'(prev_count_reg) + SWD'(cur_count_reg);
    assign idx_miss = ({1'b0, idx_reg} + 65'd1) >= 65'(s_count);
    assign lo_prod  = 40'(tend_reg[15:0]) * 40'(rate_reg);
    assign diff     = end_tick_reg - 57'(oc_reg);
    assign run_ok   = (tend_reg > pet_reg) && (rate_reg != 24'd0)
                    && (end_tick_reg > 57'(oc_reg));
    assign num_next = (diff > 57'(MAX_OUT)) ? OW'(MAX_OUT) : diff[OW-1:0];
    assign d_tq     = tq_reg - {16'b0, pet_reg};
    assign x_next   = 64'(d_tq * cur_count_reg) + 64'({16'b0, span_reg} * prev_count_reg);

    // shared divider: tick time, then buffer position with fraction
    always_comb
    begin
        div_req.start = (state_reg == lsr_pkg::ST_TQ_GO)
                      || ((state_reg == lsr_pkg::ST_XSTART) && !x_reg[63]);
        if ((state_reg == lsr_pkg::ST_TQ_GO) || (state_reg == lsr_pkg::ST_TQ_WAIT))
        begin
            div_req.dividend = {16'b0, k, 16'b0};
            div_req.divisor  = {24'b0, rate_reg};
        end
        else
        begin
            div_req.dividend = {x_reg, 16'b0};
            div_req.divisor  = span_reg;
        end
    end

    lsr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // joined buffer addressing: previous block first
    assign j       = idx_reg[SWD-1:0] + SWD'(state_reg == lsr_pkg::ST_RD_B);
    assign in_prev = j < SWD'(prev_count_reg);
    assign jrel    = in_prev ? j : j - SWD'(prev_count_reg);
    assign raddr   = jrel[AW-1:0];
    assign wr      = in_acc && !mode && (cur_count_reg < CW'(MAX_BLOCK));

    lsr_ram #(.WIDTH(32), .DEPTH(MAX_BLOCK)) u_bank0 (
        .clk   (clk),
        .we    (wr && !cur_bank_reg),
        .waddr (cur_count_reg[AW-1:0]),
        .wdata (sample),
        .raddr (raddr),
        .rdata (rd0)
    );

    lsr_ram #(.WIDTH(32), .DEPTH(MAX_BLOCK)) u_bank1 (
        .clk   (clk),
        .we    (wr && cur_bank_reg),
        .waddr (cur_count_reg[AW-1:0]),
        .wdata (sample),
        .raddr (raddr),
        .rdata (rd1)
    );

    assign rdata   = rbank_reg ? rd1 : rd0;
    assign diff_ab = $signed({rdata[31], rdata}) - $signed({a_reg[31], a_reg});
    assign prod_sh = prod_reg >>> 16;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lsr_pkg::ST_IDLE:
            begin
                if (in_acc && !mode && last_in_block)
                begin
                    state_next = lsr_pkg::ST_END_HI;
                end
            end
            lsr_pkg::ST_END_HI:  state_next = lsr_pkg::ST_END_LO;
            lsr_pkg::ST_END_LO:  state_next = lsr_pkg::ST_CHECK;
            lsr_pkg::ST_CHECK:
            begin
                state_next = run_ok ? lsr_pkg::ST_TQ_GO : lsr_pkg::ST_IDLE;
            end
            lsr_pkg::ST_TQ_GO:   state_next = lsr_pkg::ST_TQ_WAIT;
            lsr_pkg::ST_TQ_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = lsr_pkg::ST_XCALC;
                end
            end
            lsr_pkg::ST_XCALC:   state_next = lsr_pkg::ST_XSTART;
            lsr_pkg::ST_XSTART:
            begin
                state_next = x_reg[63] ? lsr_pkg::ST_IDXCHK : lsr_pkg::ST_XWAIT;
            end
            lsr_pkg::ST_XWAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = lsr_pkg::ST_IDXCHK;
                end
            end
            lsr_pkg::ST_IDXCHK:
            begin
                if (!idx_miss)
                begin
                    state_next = lsr_pkg::ST_RD_A;
                end
                else
                begin
                    state_next = pend_v_reg ? lsr_pkg::ST_FLUSH : lsr_pkg::ST_IDLE;
                end
            end
            lsr_pkg::ST_RD_A:    state_next = lsr_pkg::ST_RD_B;
            lsr_pkg::ST_RD_B:    state_next = lsr_pkg::ST_MUL;
            lsr_pkg::ST_MUL:     state_next = lsr_pkg::ST_VAL;
            lsr_pkg::ST_VAL:     state_next = lsr_pkg::ST_STORE;
            lsr_pkg::ST_STORE:
            begin
                if (store_go)
                begin
                    state_next = ((i_reg + OW'(1)) == num_reg) ? lsr_pkg::ST_FLUSH
                                                               : lsr_pkg::ST_TQ_GO;
                end
            end
            lsr_pkg::ST_FLUSH:
            begin
                if (slot_free)
                begin
                    state_next = lsr_pkg::ST_IDLE;
                end
            end
            default:             state_next = lsr_pkg::ST_IDLE;
        endcase
    end

    // block bookkeeping at the end of a run
    logic finish;
    assign finish = ((state_reg == lsr_pkg::ST_CHECK) && !run_ok)
                  || ((state_reg == lsr_pkg::ST_IDXCHK) && idx_miss && !pend_v_reg)
                  || ((state_reg == lsr_pkg::ST_FLUSH) && slot_free);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lsr_pkg::ST_IDLE;
            rate_reg       <= 24'd1000;
            cur_bank_reg   <= 1'b0;
            cur_count_reg  <= '0;
            prev_count_reg <= '0;
            pet_reg        <= '0;
            oc_reg         <= '0;
            num_reg        <= '0;
            i_reg          <= '0;
            pend_v_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                rate_reg <= cfg_rate;
            end
            if (in_acc && mode)
            begin
                cur_count_reg  <= '0;
                prev_count_reg <= '0;
                pet_reg        <= '0;
                oc_reg         <= '0;
            end
            else if (wr)
            begin
                cur_count_reg <= cur_count_reg + CW'(1);
            end
            if (state_reg == lsr_pkg::ST_END_HI)
            begin
                i_reg <= '0;
            end
            if ((state_reg == lsr_pkg::ST_CHECK) && run_ok)
            begin
                num_reg <= num_next;
            end
            if (store_go)
            begin
                pend_v_reg <= 1'b1;
                i_reg      <= i_reg + OW'(1);
            end
            if ((state_reg == lsr_pkg::ST_FLUSH) && slot_free)
            begin
                pend_v_reg <= 1'b0;
            end
            if (finish)
            begin
                oc_reg         <= oc_reg + 48'(i_reg);
                cur_bank_reg   <= !cur_bank_reg;
                prev_count_reg <= cur_count_reg;
                cur_count_reg  <= '0;
                pet_reg        <= tend_reg;
            end
            // output register
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            tend_reg <= block_end_time;
        end
        if (state_reg == lsr_pkg::ST_END_HI)
        begin
            end_hi_reg <= 56'(tend_reg[47:16]) * 56'(rate_reg);
            span_reg   <= tend_reg - pet_reg;
        end
        if (state_reg == lsr_pkg::ST_END_LO)
        begin
            end_tick_reg <= 57'(end_hi_reg) + 57'(lo_prod[39:16]);
        end
        if ((state_reg == lsr_pkg::ST_TQ_WAIT) && div_rsp.done)
        begin
            tq_reg <= div_rsp.quotient[63:0];
        end
        if (state_reg == lsr_pkg::ST_XCALC)
        begin
            x_reg <= x_next;
        end
        if ((state_reg == lsr_pkg::ST_XSTART) && x_reg[63])
        begin
            idx_reg <= '0;
            f_reg   <= '0;
        end
        if ((state_reg == lsr_pkg::ST_XWAIT) && div_rsp.done)
        begin
            idx_reg <= div_rsp.quotient[79:16];
            f_reg   <= div_rsp.quotient[15:0];
        end
        if ((state_reg == lsr_pkg::ST_RD_A) || (state_reg == lsr_pkg::ST_RD_B))
        begin
            rbank_reg <= in_prev ? !cur_bank_reg : cur_bank_reg;
        end
        if (state_reg == lsr_pkg::ST_RD_B)
        begin
            a_reg <= rdata;
        end
        if (state_reg == lsr_pkg::ST_MUL)
        begin
            prod_reg <= diff_ab * $signed({1'b0, f_reg});
        end
        if (state_reg == lsr_pkg::ST_VAL)
        begin
            v_reg <= a_reg + prod_sh[31:0];
        end
        if (push)
        begin
            value_reg     <= pend_val_reg;
            out_index_reg <= pend_k_reg;
            last_reg      <= (state_reg == lsr_pkg::ST_FLUSH);
        end
        if (store_go)
        begin
            pend_val_reg <= v_reg;
            pend_k_reg   <= k;
        end
    end

    assign out_valid   = out_valid_reg;
    assign value       = value_reg;
    assign out_index   = out_index_reg;
    assign last_of_run = last_reg;

`ifndef NO_ASSERTIONS
    // no word may still be pending while a new input is taken
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !pend_v_reg)
        else $error("pending output word left at idle");

    // gathered count never passes the block size
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        cur_count_reg <= CW'(MAX_BLOCK))
        else $error("current count beyond block size");

    // outputs written never pass the run length
    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        i_reg <= num_reg)
        else $error("more outputs than run length");

    // divider finishes only where the sequencer waits for it
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == lsr_pkg::ST_TQ_WAIT
                          || state_reg == lsr_pkg::ST_XWAIT))
        else $error("divider done outside a wait state");
`endif

endmodule
